>>> sv/scissor_rect_stack_defines.svh
// Assertion macros shared by the clip rectangle stack RTL.
`ifndef SCISSOR_RECT_STACK_DEFINES_SVH
`define SCISSOR_RECT_STACK_DEFINES_SVH

// Condition holds at every edge out of reset.
`define SCRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define SCRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define SCRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/scrs_pkg.sv
// Types, codes and edge mapping function for the clip rectangle stack.
`default_nettype none

package scrs_pkg;

  localparam int SCRS_STACK_DEPTH = 128;

  typedef enum logic [2:0] {
    KIND_PUSH_CLIP = 3'd0,
    KIND_PUSH_NE   = 3'd1,
    KIND_PUSH_RAW  = 3'd2,
    KIND_POP       = 3'd3,
    KIND_RESET     = 3'd4,
    KIND_QUERY     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_OVF = 2'd1,
    STAT_UDF = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MAP,
    S_POP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [23:0] virt_left;
    logic signed [23:0] virt_top;
    logic signed [23:0] virt_right;
    logic signed [23:0] virt_bottom;
    logic signed [15:0] scr_left;
    logic signed [15:0] scr_top;
    logic signed [15:0] scr_right;
    logic signed [15:0] scr_bottom;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] top_left;
    logic signed [15:0] top_top;
    logic signed [15:0] top_right;
    logic signed [15:0] top_bottom;
    logic signed [23:0] top_vleft;
    logic signed [23:0] top_vtop;
    logic signed [23:0] top_vright;
    logic signed [23:0] top_vbottom;
    logic               not_empty;
    logic [1:0]         status;
    logic [7:0]         level;
  } out_item_t;

  // One stack entry: screen rectangle and the virtual rectangle behind it.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic signed [23:0] vleft;
    logic signed [23:0] vtop;
    logic signed [23:0] vright;
    logic signed [23:0] vbottom;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Add offset to scaled edge, truncate toward zero by 2^16, saturate to 16 bits.
  function automatic logic signed [15:0] map_edge(input logic signed [40:0] prod,
                                                  input logic signed [23:0] off);
    logic signed [41:0] s;
    logic signed [41:0] b;
    logic signed [25:0] q;
    s = {prod[40], prod} + {{10{off[23]}}, off, 8'b0};
    b = s + (s[41] ? 42'sd65535 : 42'sd0);
    q = b[41:16];
    if (q > 26'sd32767) begin
      map_edge = 16'sh7fff;
    end else if (q < -26'sd32768) begin
      map_edge = 16'sh8000;
    end else begin
      map_edge = q[15:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/scrs_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module scrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/scissor_rect_stack.sv
// Clip rectangle stack: top entry cached in registers, stack body in RAM.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   input   | in_valid, in_stall, in_data    | in
//   result  | out_valid, out_stall, out_data | out
//   config  | cfg_we, cfg_idx, cfg_wdata     | in
//
// One item at a time. Query, raw push, reset and a refused pop go from accept
// straight to the final stage; a pop first loads the new top from one RAM read;
// a clipped push passes a multiply stage, then an offset/round/saturate stage.
// A stalled result holds the final stage until the output register frees up.
// Synchronous active-low reset: level 1, entry 0 and the top entry all zero.
`default_nettype none

`include "scissor_rect_stack_defines.svh"

module scissor_rect_stack
  import scrs_pkg::*;
#(
  parameter int STACK_DEPTH = SCRS_STACK_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [23:0] cfg_wdata
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] CFG_SCALE_X  = 2'd0;
  localparam logic [1:0] CFG_SCALE_Y  = 2'd1;
  localparam logic [1:0] CFG_OFFSET_X = 2'd2;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd3;

  state_t state_r, state_nxt;

  logic [15:0]        scale_x_r, scale_y_r;
  logic signed [23:0] offset_x_r, offset_y_r;

  in_item_t cmd_r;
  logic     pop_ref_r;

  logic signed [40:0] prod_r [4];
  logic signed [15:0] edge_r [4];

  logic [LW-1:0] level_r, level_nxt;
  entry_t        top_r, top_nxt;
  logic          ent0_vld_r, ent0_vld_nxt;

  logic               out_valid_r;
  out_item_t          out_data_r;
  out_item_t          res;
  logic [LW+7:0]      lvl_ext;

  logic               in_acc;
  logic               out_free;
  logic               out_load;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [LW-1:0]      pop_addr;

  logic signed [15:0] cr_left, cr_top, cr_right, cr_bottom;
  logic               ne;
  logic               push_req;
  entry_t             push_ent;
  entry_t             clip_ent, raw_ent, rst_ent;
  logic               full;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (level_r == LW'(STACK_DEPTH));
  assign pop_addr = level_r - LW'(2);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r  <= 16'd256;
      scale_y_r  <= 16'd256;
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SCALE_X:  scale_x_r  <= cfg_wdata[15:0];
        CFG_SCALE_Y:  scale_y_r  <= cfg_wdata[15:0];
        CFG_OFFSET_X: offset_x_r <= cfg_wdata;
        CFG_OFFSET_Y: offset_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Command capture and mapping stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_data;
      pop_ref_r <= (level_r == LW'(1));
    end
    if (state_r == S_MUL) begin
      prod_r[0] <= cmd_r.virt_left   * $signed({1'b0, scale_x_r});
      prod_r[1] <= cmd_r.virt_top    * $signed({1'b0, scale_y_r});
      prod_r[2] <= cmd_r.virt_right  * $signed({1'b0, scale_x_r});
      prod_r[3] <= cmd_r.virt_bottom * $signed({1'b0, scale_y_r});
    end
    if (state_r == S_MAP) begin
      edge_r[0] <= map_edge(prod_r[0], offset_x_r);
      edge_r[1] <= map_edge(prod_r[1], offset_y_r);
      edge_r[2] <= map_edge(prod_r[2], offset_x_r);
      edge_r[3] <= map_edge(prod_r[3], offset_y_r);
    end
  end

  // Intersection with the cached top entry
  always_comb begin
    cr_left   = (edge_r[0] > top_r.left)   ? edge_r[0] : top_r.left;
    cr_top    = (edge_r[1] > top_r.top)    ? edge_r[1] : top_r.top;
    cr_right  = (edge_r[2] < top_r.right)  ? edge_r[2] : top_r.right;
    cr_bottom = (edge_r[3] < top_r.bottom) ? edge_r[3] : top_r.bottom;
    ne        = (cr_left < cr_right) && (cr_top < cr_bottom);

    clip_ent = '{left: cr_left, top: cr_top, right: cr_right, bottom: cr_bottom,
                 vleft: cmd_r.virt_left, vtop: cmd_r.virt_top,
                 vright: cmd_r.virt_right, vbottom: cmd_r.virt_bottom};
    raw_ent  = '{left: cmd_r.scr_left, top: cmd_r.scr_top,
                 right: cmd_r.scr_right, bottom: cmd_r.scr_bottom,
                 vleft: cmd_r.virt_left, vtop: cmd_r.virt_top,
                 vright: cmd_r.virt_right, vbottom: cmd_r.virt_bottom};
    rst_ent  = '{left: cmd_r.scr_left, top: cmd_r.scr_top,
                 right: cmd_r.scr_right, bottom: cmd_r.scr_bottom,
                 vleft: {cmd_r.scr_left, 8'b0}, vtop: {cmd_r.scr_top, 8'b0},
                 vright: {cmd_r.scr_right, 8'b0}, vbottom: {cmd_r.scr_bottom, 8'b0}};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.kind inside {KIND_PUSH_CLIP, KIND_PUSH_NE}) begin
            state_nxt = S_MUL;
          end else if (in_data.kind == KIND_POP && level_r > LW'(1)) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL:  state_nxt = S_MAP;
      S_MAP:  state_nxt = S_DONE;
      S_POP:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Stack update, RAM access and result
  always_comb begin
    level_nxt    = level_r;
    top_nxt      = top_r;
    ent0_vld_nxt = ent0_vld_r;
    ram_we       = 1'b0;
    ram_waddr    = level_r[AW-1:0];
    ram_wdata    = top_r;
    ram_re       = 1'b0;
    ram_raddr    = pop_addr[AW-1:0];
    out_load     = 1'b0;
    push_req     = 1'b0;
    push_ent     = raw_ent;
    res.not_empty = 1'b0;
    res.status    = STAT_OK;

    case (state_r)
      S_IDLE: begin
        // read the entry below the top as the pop is taken
        if (in_acc && in_data.kind == KIND_POP && level_r > LW'(1)) begin
          ram_re = 1'b1;
        end
      end
      S_POP: begin
        // entry 0 reads as zero until a reset command writes it
        if (level_r == LW'(2) && !ent0_vld_r) begin
          top_nxt = '0;
        end else begin
          top_nxt = entry_t'(ram_rdata);
        end
        level_nxt = level_r - LW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          case (cmd_r.kind)
            KIND_PUSH_CLIP, KIND_PUSH_NE: begin
              res.not_empty = ne;
              push_req      = (cmd_r.kind == KIND_PUSH_CLIP) || ne;
              push_ent      = clip_ent;
            end
            KIND_PUSH_RAW: begin
              push_req = 1'b1;
              push_ent = raw_ent;
            end
            KIND_POP: begin
              if (pop_ref_r) begin
                res.status = STAT_UDF;
              end
            end
            KIND_RESET: begin
              ram_we       = 1'b1;
              ram_waddr    = '0;
              ram_wdata    = rst_ent;
              top_nxt      = rst_ent;
              level_nxt    = LW'(1);
              ent0_vld_nxt = 1'b1;
            end
            default: ;
          endcase
          if (push_req) begin
            if (full) begin
              res.status = STAT_OVF;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = push_ent;
              top_nxt   = push_ent;
              level_nxt = level_r + LW'(1);
            end
          end
        end
      end
      default: ;
    endcase

    lvl_ext         = {8'b0, level_nxt};
    res.top_left    = top_nxt.left;
    res.top_top     = top_nxt.top;
    res.top_right   = top_nxt.right;
    res.top_bottom  = top_nxt.bottom;
    res.top_vleft   = top_nxt.vleft;
    res.top_vtop    = top_nxt.vtop;
    res.top_vright  = top_nxt.vright;
    res.top_vbottom = top_nxt.vbottom;
    res.level       = lvl_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= LW'(1);
      top_r       <= '0;
      ent0_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      level_r    <= level_nxt;
      top_r      <= top_nxt;
      ent0_vld_r <= ent0_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  scrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  `SCRS_ASSERT_ALWAYS(a_level_range, (level_r != '0) && (level_r <= LW'(STACK_DEPTH)), "stack level out of range")
  `SCRS_ASSERT_SAME(a_write_in_done, ram_we, (state_r == S_DONE) && out_free, "stack write outside final stage")
  `SCRS_ASSERT_NEXT(a_pop_drops_level, state_r == S_POP, level_r == ($past(level_r) - LW'(1)), "pop did not lower level")
  `SCRS_ASSERT_NEXT(a_ovf_at_full, out_load && (res.status == STAT_OVF), level_r == LW'(STACK_DEPTH), "overflow reported below full")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for scissor_rect_stack: directed and random commands vs a stack model.
`timescale 1ns / 1ps

module testbench
  import scrs_pkg::*;
();

  localparam int STACK_DEPTH = SCRS_STACK_DEPTH;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 75;
  localparam int FILL_ITEMS  = 132;

  localparam logic [1:0] REG_SCALE_X  = 2'd0;
  localparam logic [1:0] REG_SCALE_Y  = 2'd1;
  localparam logic [1:0] REG_OFFSET_X = 2'd2;
  localparam logic [1:0] REG_OFFSET_Y = 2'd3;

  // Kinds outside the enum behave as a query.
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = '0;
  logic [23:0] cfg_wdata = '0;

  scissor_rect_stack DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Model state: stack body, fill level and register copies.
  entry_t             clip_stack [STACK_DEPTH];
  int unsigned        stack_fill;
  logic [15:0]        scale_x_q;
  logic [15:0]        scale_y_q;
  logic signed [23:0] offset_x_q;
  logic signed [23:0] offset_y_q;

  in_item_t  command_queue [$];
  out_item_t top_reports_due [$];
  int        mismatch_count = 0;
  int        results_seen   = 0;
  int        quiet_cycles;
  int        send_idle_pct;
  int        stall_pct;

  function automatic void reset_model();
    foreach (clip_stack[i]) clip_stack[i] = '0;
    stack_fill = 1;
    scale_x_q  = 16'd256;
    scale_y_q  = 16'd256;
    offset_x_q = '0;
    offset_y_q = '0;
  endfunction

  // Scale and offset one edge, truncate toward zero, saturate to 16 bits.
  function automatic logic signed [15:0] scale_edge(input logic signed [23:0] v,
                                                    input logic [15:0] sc,
                                                    input logic signed [23:0] off);
    longint sum;
    longint q;
    sum = longint'(v) * longint'(sc) + longint'(off) * 256;
    q = (sum < 0) ? -((-sum) >>> 16) : (sum >>> 16);
    if (q > 32767) return 16'sh7fff;
    if (q < -32768) return 16'sh8000;
    return 16'(q);
  endfunction

  function automatic logic [1:0] push_entry(input entry_t e);
    if (stack_fill >= STACK_DEPTH) return STAT_OVF;
    clip_stack[stack_fill] = e;
    stack_fill++;
    return STAT_OK;
  endfunction

  function automatic out_item_t apply_command(input in_item_t c);
    out_item_t          r;
    entry_t             e;
    entry_t             cur;
    logic signed [15:0] x0, y0, x1, y1;
    logic               hit;
    logic [1:0]         st;
    hit = 1'b0;
    st  = STAT_OK;
    cur = clip_stack[stack_fill - 1];
    e.vleft   = c.virt_left;
    e.vtop    = c.virt_top;
    e.vright  = c.virt_right;
    e.vbottom = c.virt_bottom;
    e.left    = c.scr_left;
    e.top     = c.scr_top;
    e.right   = c.scr_right;
    e.bottom  = c.scr_bottom;
    case (c.kind)
      KIND_PUSH_CLIP, KIND_PUSH_NE: begin
        x0 = scale_edge(c.virt_left, scale_x_q, offset_x_q);
        y0 = scale_edge(c.virt_top, scale_y_q, offset_y_q);
        x1 = scale_edge(c.virt_right, scale_x_q, offset_x_q);
        y1 = scale_edge(c.virt_bottom, scale_y_q, offset_y_q);
        e.left   = (cur.left > x0) ? cur.left : x0;
        e.top    = (cur.top > y0) ? cur.top : y0;
        e.right  = (cur.right < x1) ? cur.right : x1;
        e.bottom = (cur.bottom < y1) ? cur.bottom : y1;
        hit = (e.left < e.right) && (e.top < e.bottom);
        if (c.kind == KIND_PUSH_CLIP || hit) st = push_entry(e);
      end
      KIND_PUSH_RAW: st = push_entry(e);
      KIND_POP: begin
        if (stack_fill <= 1) st = STAT_UDF;
        else stack_fill--;
      end
      KIND_RESET: begin
        e.vleft   = {c.scr_left, 8'h00};
        e.vtop    = {c.scr_top, 8'h00};
        e.vright  = {c.scr_right, 8'h00};
        e.vbottom = {c.scr_bottom, 8'h00};
        clip_stack[0] = e;
        stack_fill = 1;
      end
      default: ;
    endcase
    cur = clip_stack[stack_fill - 1];
    r.top_left    = cur.left;
    r.top_top     = cur.top;
    r.top_right   = cur.right;
    r.top_bottom  = cur.bottom;
    r.top_vleft   = cur.vleft;
    r.top_vtop    = cur.vtop;
    r.top_vright  = cur.vright;
    r.top_vbottom = cur.vbottom;
    r.not_empty   = hit;
    r.status      = st;
    r.level       = 8'(stack_fill);
    return r;
  endfunction

  // Tidy items carry pixel-scale rectangles; others carry raw random bits.
  function automatic in_item_t make_cmd(input logic [2:0] k, input bit tidy);
    in_item_t c;
    int x, y, w, h;
    c.kind        = k;
    c.virt_left   = 24'($urandom);
    c.virt_top    = 24'($urandom);
    c.virt_right  = 24'($urandom);
    c.virt_bottom = 24'($urandom);
    c.scr_left    = 16'($urandom);
    c.scr_top     = 16'($urandom);
    c.scr_right   = 16'($urandom);
    c.scr_bottom  = 16'($urandom);
    if (tidy) begin
      x = $urandom_range(4000);
      x -= 2000;
      y = $urandom_range(4000);
      y -= 2000;
      w = $urandom_range(1200);
      h = $urandom_range(1200);
      c.virt_left   = 24'(x * 256 + int'($urandom_range(511)) - 256);
      c.virt_top    = 24'(y * 256 + int'($urandom_range(511)) - 256);
      c.virt_right  = 24'((x + w) * 256 + int'($urandom_range(511)) - 256);
      c.virt_bottom = 24'((y + h) * 256 + int'($urandom_range(511)) - 256);
      c.scr_left    = 16'(x - int'($urandom_range(800)));
      c.scr_top     = 16'(y - int'($urandom_range(800)));
      c.scr_right   = 16'(x + w + int'($urandom_range(800)));
      c.scr_bottom  = 16'(y + h + int'($urandom_range(800)));
    end
    return c;
  endfunction

  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 30) return KIND_PUSH_CLIP;
    if (r < 45) return KIND_PUSH_NE;
    if (r < 55) return KIND_PUSH_RAW;
    if (r < 78) return KIND_POP;
    if (r < 83) return KIND_RESET;
    if (r < 93) return KIND_QUERY;
    return (r < 96) ? KIND_SPARE_6 : KIND_SPARE_7;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string field, input logic [23:0] got,
                               input logic [23:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                results_seen, field, got, want));
  endtask

  task automatic wait_for_drain();
    while (command_queue.size() != 0 || in_valid || top_reports_due.size() != 0)
      @(posedge clk);
  endtask

  // Driver: predict on accept, then present the next item or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) top_reports_due.push_back(apply_command(in_data));
      if (!in_valid || !in_stall) begin
        if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= command_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (top_reports_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want = top_reports_due.pop_front();
          compare_field("top_left", out_data.top_left, want.top_left);
          compare_field("top_top", out_data.top_top, want.top_top);
          compare_field("top_right", out_data.top_right, want.top_right);
          compare_field("top_bottom", out_data.top_bottom, want.top_bottom);
          compare_field("top_vleft", out_data.top_vleft, want.top_vleft);
          compare_field("top_vtop", out_data.top_vtop, want.top_vtop);
          compare_field("top_vright", out_data.top_vright, want.top_vright);
          compare_field("top_vbottom", out_data.top_vbottom, want.top_vbottom);
          compare_field("not_empty", out_data.not_empty, want.not_empty);
          compare_field("status", out_data.status, want.status);
          compare_field("level", out_data.level, want.level);
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("scissor_rect_stack regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t    cmd;
    logic [23:0] cfg_vals [4];
    send_idle_pct  = 0;
    stall_pct      = 0;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty stack, underflow, full screen, nesting, extremes.
    command_queue.push_back(make_cmd(KIND_QUERY, 1'b1));
    command_queue.push_back(make_cmd(KIND_POP, 1'b1));
    cmd = make_cmd(KIND_RESET, 1'b1);
    cmd.scr_left   = 16'sh8000;
    cmd.scr_top    = 16'sh8000;
    cmd.scr_right  = 16'sh7fff;
    cmd.scr_bottom = 16'sh7fff;
    command_queue.push_back(cmd);
    cmd = make_cmd(KIND_PUSH_CLIP, 1'b1);
    cmd.virt_left   = 24'sd25728;
    cmd.virt_top    = 24'sd12800;
    cmd.virt_right  = 24'sd77055;
    cmd.virt_bottom = 24'sd51200;
    command_queue.push_back(cmd);
    // Empty result: not stored.
    cmd = make_cmd(KIND_PUSH_NE, 1'b1);
    cmd.virt_left  = 24'sd80000;
    cmd.virt_right = 24'sd1000;
    command_queue.push_back(cmd);
    cmd = make_cmd(KIND_PUSH_NE, 1'b1);
    cmd.virt_left   = 24'sd38400;
    cmd.virt_top    = 24'sd15360;
    cmd.virt_right  = 24'sd64000;
    cmd.virt_bottom = 24'sd48640;
    command_queue.push_back(cmd);
    // Zero width, stored anyway.
    cmd = make_cmd(KIND_PUSH_CLIP, 1'b1);
    cmd.virt_right = cmd.virt_left;
    command_queue.push_back(cmd);
    cmd = make_cmd(KIND_PUSH_RAW, 1'b0);
    cmd.virt_left   = 24'sh800000;
    cmd.virt_top    = 24'sh7fffff;
    cmd.virt_right  = 24'sh7fffff;
    cmd.virt_bottom = 24'sh800000;
    cmd.scr_left    = 16'sh7fff;
    cmd.scr_top     = 16'sh8000;
    cmd.scr_right   = 16'sh8000;
    cmd.scr_bottom  = 16'sh7fff;
    command_queue.push_back(cmd);
    command_queue.push_back(make_cmd(KIND_QUERY, 1'b0));
    command_queue.push_back(make_cmd(KIND_SPARE_6, 1'b0));
    command_queue.push_back(make_cmd(KIND_SPARE_7, 1'b0));
    repeat (5) command_queue.push_back(make_cmd(KIND_POP, 1'b0));
    // Extreme virtual edges and negative fractions truncated toward zero.
    cmd = make_cmd(KIND_PUSH_CLIP, 1'b0);
    cmd.virt_left   = 24'sh800000;
    cmd.virt_top    = -24'sd384;
    cmd.virt_right  = 24'sh7fffff;
    cmd.virt_bottom = -24'sd128;
    command_queue.push_back(cmd);
    cmd = make_cmd(KIND_PUSH_NE, 1'b0);
    cmd.virt_left   = -24'sd1;
    cmd.virt_top    = -24'sd255;
    cmd.virt_right  = 24'sd255;
    cmd.virt_bottom = 24'sd1;
    command_queue.push_back(cmd);
    command_queue.push_back(make_cmd(KIND_PUSH_NE, 1'b0));
    command_queue.push_back(make_cmd(KIND_RESET, 1'b1));
    command_queue.push_back(make_cmd(KIND_PUSH_RAW, 1'b1));
    command_queue.push_back(make_cmd(KIND_PUSH_CLIP, 1'b1));
    wait_for_drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      case (p)
        0: begin
          cfg_vals[REG_SCALE_X]  = 24'd256;
          cfg_vals[REG_SCALE_Y]  = 24'd256;
          cfg_vals[REG_OFFSET_X] = 24'd0;
          cfg_vals[REG_OFFSET_Y] = 24'd0;
        end
        1: begin
          cfg_vals[REG_SCALE_X]  = 24'd65535;
          cfg_vals[REG_SCALE_Y]  = 24'd65535;
          cfg_vals[REG_OFFSET_X] = 24'h7fffff;
          cfg_vals[REG_OFFSET_Y] = 24'h800000;
        end
        2: begin
          cfg_vals[REG_SCALE_X]  = 24'd0;
          cfg_vals[REG_SCALE_Y]  = 24'd0;
          cfg_vals[REG_OFFSET_X] = 24'h800000;
          cfg_vals[REG_OFFSET_Y] = 24'h7fffff;
        end
        3: begin
          cfg_vals[REG_SCALE_X]  = 24'd128;
          cfg_vals[REG_SCALE_Y]  = 24'd512;
          cfg_vals[REG_OFFSET_X] = 24'(int'($urandom_range(200000)) - 100000);
          cfg_vals[REG_OFFSET_Y] = 24'(int'($urandom_range(200000)) - 100000);
        end
        6: begin
          cfg_vals[REG_SCALE_X]  = 24'($urandom_range(65535));
          cfg_vals[REG_SCALE_Y]  = 24'($urandom_range(65535));
          cfg_vals[REG_OFFSET_X] = 24'($urandom);
          cfg_vals[REG_OFFSET_Y] = 24'($urandom);
        end
        default: begin
          cfg_vals[REG_SCALE_X]  = 24'($urandom_range(1024));
          cfg_vals[REG_SCALE_Y]  = 24'($urandom_range(1024));
          cfg_vals[REG_OFFSET_X] = 24'(int'($urandom_range(400000)) - 200000);
          cfg_vals[REG_OFFSET_Y] = 24'(int'($urandom_range(400000)) - 200000);
        end
      endcase
      // The block is idle here, so the model copy can change right away.
      for (int r = 0; r < 4; r++) begin
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= 2'(r);
        cfg_wdata <= cfg_vals[r];
        case (2'(r))
          REG_SCALE_X:  scale_x_q  = cfg_vals[r][15:0];
          REG_SCALE_Y:  scale_y_q  = cfg_vals[r][15:0];
          REG_OFFSET_X: offset_x_q = cfg_vals[r];
          default:      offset_y_q = cfg_vals[r];
        endcase
      end
      @(posedge clk);
      cfg_we <= 1'b0;

      // Fill to the top and push past it to reach overflow.
      if (p == 0 || p == 4) begin
        for (int i = 0; i < FILL_ITEMS; i++)
          command_queue.push_back(make_cmd(($urandom_range(3) == 0) ? KIND_PUSH_CLIP
                                                                   : KIND_PUSH_RAW, 1'b1));
        repeat (4) command_queue.push_back(make_cmd(KIND_PUSH_NE, 1'b1));
      end
      for (int i = 0; i < PHASE_ITEMS; i++)
        command_queue.push_back(make_cmd(pick_kind(), $urandom_range(99) < 80));
      wait_for_drain();
    end

    repeat (20) @(posedge clk);
    if (top_reports_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", top_reports_due.size()));
    if (mismatch_count == 0) begin
      $display("scissor_rect_stack regression: pass");
    end else begin
      $display("scissor_rect_stack regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/scrs_pkg.sv
sv/scrs_ram.sv
sv/scissor_rect_stack.sv
sim/testbench.sv
